/* hw/rtl/utf8_stream_sanitizer_defines.svh */
// Assertion macros shared by the UTF-8 stream sanitizer RTL.
`ifndef UTF8_STREAM_SANITIZER_DEFINES_SVH
`define UTF8_STREAM_SANITIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define U8S_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define U8S_ASSERT_IMPL(lbl, ante, cons, msg)
`define U8S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/u8s_pkg.sv */
// Shared types, decision codes and UTF-8 classification functions.
`default_nettype none

package u8s_pkg;

	localparam logic [7:0] QMARK = 8'h3F;

	// Decision for the byte at the head of the lookahead buffer
	localparam logic [1:0] DEC_WAIT    = 2'd0;
	localparam logic [1:0] DEC_KEEP    = 2'd1;
	localparam logic [1:0] DEC_REPLACE = 2'd2;

	typedef struct packed {
		logic load;   // take the input item into the buffer
		logic step;   // emit the head byte and shift the buffer
	} ctrl_cmd_t;

	typedef struct packed {
		logic       empty;     // buffer holds no byte
		logic       out_free;  // output register can take a byte
		logic [1:0] dec;       // decision for the head byte
		logic [2:0] cnt;       // bytes held in the buffer
	} dp_stat_t;

	// Announced sequence length from a lead byte; zero marks a byte that can never start one
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		begin
			if (b < 8'h80)      len = 3'd1;
			else if (b < 8'hC0) len = 3'd0;
			else if (b < 8'hE0) len = 3'd2;
			else if (b < 8'hF0) len = 3'd3;
			else if (b < 8'hF8) len = 3'd4;
			else                len = 3'd0;
			return len;
		end
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b >= 8'h80) && (b <= 8'hBF);
	endfunction

	// Strict well-formedness of a sequence of the given length starting at b0
	function automatic logic seq_valid(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] len);
		logic ok;
		begin
			case (len)
				3'd1: ok = (b0 <= 8'h7F);
				3'd2: ok = (b0 >= 8'hC2) && (b0 <= 8'hDF) && is_cont(b1);
				3'd3: begin
					ok = (b0 >= 8'hE0) && (b0 <= 8'hEF) && is_cont(b1) && is_cont(b2);
					if (b0 == 8'hE0 && !(b1 >= 8'hA0 && b1 <= 8'hBF)) ok = 1'b0;
					if (b0 == 8'hED && !(b1 >= 8'h80 && b1 <= 8'h9F)) ok = 1'b0;
				end
				3'd4: begin
					ok = (b0 >= 8'hF0) && (b0 <= 8'hF4) && is_cont(b1) && is_cont(b2)
						&& is_cont(b3);
					if (b0 == 8'hF0 && !(b1 >= 8'h90 && b1 <= 8'hBF)) ok = 1'b0;
					if (b0 == 8'hF4 && !(b1 >= 8'h80 && b1 <= 8'h8F)) ok = 1'b0;
				end
				default: ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/u8s_dpath.sv */
// Datapath: lookahead buffer, head-byte decision and output register.
`default_nettype none

module u8s_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u8s_pkg::ctrl_cmd_t cmd,
	output u8s_pkg::dp_stat_t       stat,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tuser,
	output logic                    m_tlast
);

	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic [1:0] pass_q;
	logic       last_q;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_user_q;
	logic       m_last_q;

	logic [2:0] head_len;
	logic [1:0] dec;
	logic       new_seq;

	assign head_len = u8s_pkg::seq_len(buf_q[0]);

	always_comb begin
		new_seq = 1'b0;
		if (pass_q != 2'd0) begin
			dec = u8s_pkg::DEC_KEEP;
		end else if (head_len == 3'd0) begin
			dec = u8s_pkg::DEC_REPLACE;
		end else if (head_len > cnt_q) begin
			dec = last_q ? u8s_pkg::DEC_REPLACE : u8s_pkg::DEC_WAIT;
		end else if (u8s_pkg::seq_valid(buf_q[0], buf_q[1], buf_q[2], buf_q[3], head_len)) begin
			dec     = u8s_pkg::DEC_KEEP;
			new_seq = 1'b1;
		end else begin
			dec = u8s_pkg::DEC_REPLACE;
		end
	end

	assign stat.empty    = (cnt_q == 3'd0);
	assign stat.out_free = !m_valid_q || m_tready;
	assign stat.dec      = dec;
	assign stat.cnt      = cnt_q;

	// Buffer contents need no reset: only entries below the count are used
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= in_byte;
		end else if (cmd.step) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			pass_q <= 2'd0;
			last_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= cnt_q + 3'd1;
			last_q <= in_last;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 3'd1;
			if (new_seq) pass_q <= 2'(head_len - 3'd1);
			else if (pass_q != 2'd0) pass_q <= pass_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.step) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			m_data_q <= (dec == u8s_pkg::DEC_KEEP) ? buf_q[0] : u8s_pkg::QMARK;
			m_user_q <= (dec == u8s_pkg::DEC_REPLACE);
			m_last_q <= last_q && (cnt_q == 3'd1);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

`default_nettype wire

/* hw/rtl/u8s_ctrl.sv */
// Controller: sequences byte intake and per-byte emission.
`default_nettype none

module u8s_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u8s_pkg::dp_stat_t stat,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output u8s_pkg::ctrl_cmd_t     cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;
	logic drained;

	assign drained = stat.empty || (stat.dec == u8s_pkg::DEC_WAIT);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (drained) begin
					s_tready = 1'b1;
					if (s_tvalid) cmd.load = 1'b1;
					else          state_d  = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/utf8_stream_sanitizer.sv */
// Top level of the UTF-8 stream sanitizer: controller, datapath and checks.
// Usage:
//   Slave channel s_* takes one raw byte per item (s_tdata) with s_tlast on the
//   final byte of a string. Master channel m_* returns exactly one byte per
//   input byte: the original byte, or '?' (0x3F) with m_tuser set where the byte
//   opened an invalid or cut-short sequence. m_tlast marks the final byte of a
//   string; at that point all held bytes have been flushed.
//   Up to three bytes of a pending multi-byte sequence are held until the
//   sequence is complete or the string ends, so output lags input accordingly.
//   A byte that completes a decision is loaded into the lookahead buffer and
//   then stepped into the single output register before it shows up on m_*.
//   Intake and emission never happen together, so ASCII bytes alternate
//   between them, and a flush at string end emits one byte per cycle while
//   m_tready stays high, through the serial emission path of one register.
//   Reset (arst_n low, asynchronous) empties the buffer and output register.
//   When m_tready is low the output register holds its item, emission stops,
//   and intake stops once the buffer can no longer wait for more bytes.
`default_nettype none
`include "utf8_stream_sanitizer_defines.svh"

module utf8_stream_sanitizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tuser,   // [0] out_replaced
	output logic            m_tlast
);

	u8s_pkg::ctrl_cmd_t cmd;
	u8s_pkg::dp_stat_t  stat;

	u8s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	u8s_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Lookahead never exceeds three bytes when a new byte arrives
	`U8S_ASSERT_IMPL(a_load_room, cmd.load, stat.cnt <= 3'd3, "lookahead overflow on load")
	// A loaded byte is held in the buffer on the next cycle
	`U8S_ASSERT_NEXT(a_load_held, cmd.load, stat.cnt != 3'd0, "loaded byte lost")
	// Emission only happens for a decided head byte
	`U8S_ASSERT_IMPL(a_step_decided, cmd.step,
		!stat.empty && (stat.dec != u8s_pkg::DEC_WAIT), "emit without decision")
	// A replaced byte always carries the question mark
	`U8S_ASSERT_IMPL(a_repl_qmark, m_tvalid && m_tuser, m_tdata == u8s_pkg::QMARK,
		"replacement byte is not a question mark")

endmodule

`default_nettype wire
